// ===== design/tfhs_pkg.sv =====
// Shared types, constants and helpers for the trajectory frame header scanner.
`default_nettype none
package tfhs_pkg;

  localparam int OFFSET_BITS_DEF = 48;
  localparam int FIELD_OFS_W     = 48;
  localparam int WORD_W          = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int CFG_ADDR_W      = 1;
  localparam int OUT_TDATA_W     = 3 * FIELD_OFS_W + 3 * WORD_W;

  localparam logic [WORD_W-1:0] MAGIC_RESET = 32'd1995;

  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_WORD = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SWAP_BYTES = 1'd1;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COUNT  = 2'd1,
    PH_STEP   = 2'd2,
    PH_TIME   = 2'd3
  } phase_t;

  // Header words as they leave the front, already byte-ordered.
  typedef struct packed {
    logic [WORD_W-1:0] time_bits;
    logic [WORD_W-1:0] step_number;
    logic [WORD_W-1:0] atom_count;
  } hdr_words_t;

  function automatic logic [WORD_W-1:0] byte_swap32(input logic [WORD_W-1:0] v);
    byte_swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== design/trajectory_frame_header_scanner.sv =====
// Trajectory frame header scanner: finds frame headers in a word stream and reports them.
//
// Input stream in_*: one 32-bit file word per request, in read order. A word equal
// to the magic register opens a header; the next three words are the atom count,
// step and time bits (byte-reversed when swap is set). The first complete header
// locks the atom count; each complete header with that count gives one request on
// out_* carrying frame number, count, step, time bits, magic word offset and the
// distance from the previous reported frame's offset.
// Throughput: one word per cycle while in_tready is high. The front pushes each
// complete header into a 4-entry header queue, and the back end drains one record
// per cycle into the output register while that register is free or being taken.
// When the receiver stalls, the output register holds, the queue fills and
// in_tready drops only once the queue is full; words that do not close a header
// are still blocked then. Config writes (cfg_*) are registered, no read-back.
// Synchronous reset clears phase, counters, the count lock and all valids;
// magic returns to 1995 and swapping is off.
`default_nettype none
module trajectory_frame_header_scanner #(
  parameter int OFFSET_BITS = tfhs_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [tfhs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [tfhs_pkg::WORD_W-1:0]        cfg_wdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [tfhs_pkg::WORD_W-1:0]        in_tdata,   // [31:0] word
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [47:0] frame_number, [79:48] atom_count, [111:80] step_number,
  // [143:112] time_bits, [191:144] word_offset, [239:192] offset_delta
  output logic [tfhs_pkg::OUT_TDATA_W-1:0]        out_tdata
);
  import tfhs_pkg::*;

  localparam int REC_W = OFFSET_BITS + $bits(hdr_words_t);

  logic                   in_acc, push, pop, q_full, q_empty;
  hdr_words_t             push_hdr, q_hdr;
  logic [OFFSET_BITS-1:0] push_pos, q_pos;
  logic [REC_W-1:0]       q_rd;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  tfhs_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_word   (in_tdata),
    .push      (push),
    .push_hdr  (push_hdr),
    .push_pos  (push_pos)
  );

  tfhs_queue #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_pos, push_hdr}),
    .pop       (pop),
    .pop_data  (q_rd),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign q_hdr = q_rd[$bits(hdr_words_t)-1:0];
  assign q_pos = q_rd[REC_W-1:$bits(hdr_words_t)];

  tfhs_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_hdr      (q_hdr),
    .q_pos      (q_pos),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== design/tfhs_front.sv =====
// Front end: takes stream words, tracks header phase and word offsets, builds header records.
`default_nettype none
module tfhs_front #(
  parameter int OFFSET_BITS = tfhs_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tfhs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [tfhs_pkg::WORD_W-1:0]       cfg_wdata,
  input  wire logic                              in_acc,
  input  wire logic [tfhs_pkg::WORD_W-1:0]       in_word,
  output logic                                   push,
  output tfhs_pkg::hdr_words_t                   push_hdr,
  output logic [OFFSET_BITS-1:0]                 push_pos
);
  import tfhs_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0]  word_cnt_r, word_cnt_nxt;
  logic [OFFSET_BITS-1:0]  magic_pos_r, magic_pos_nxt;
  logic [WORD_W-1:0]       pend_count_r, pend_count_nxt;
  logic [WORD_W-1:0]       pend_step_r, pend_step_nxt;
  logic [WORD_W-1:0]       magic_r;
  logic                    swap_r;
  logic [WORD_W-1:0]       hdr_word;

  assign hdr_word = swap_r ? byte_swap32(in_word) : in_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= MAGIC_RESET;
      swap_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_MAGIC_WORD: magic_r <= cfg_wdata;
        REG_SWAP_BYTES: swap_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      unique case (phase_r)
        PH_SEARCH: if (in_word == magic_r) phase_nxt = PH_COUNT;
        PH_COUNT:  phase_nxt = PH_STEP;
        PH_STEP:   phase_nxt = PH_TIME;
        PH_TIME:   phase_nxt = PH_SEARCH;
        default:   phase_nxt = PH_SEARCH;
      endcase
    end
  end

  // outputs and datapath
  always_comb begin
    push           = 1'b0;
    word_cnt_nxt   = word_cnt_r;
    magic_pos_nxt  = magic_pos_r;
    pend_count_nxt = pend_count_r;
    pend_step_nxt  = pend_step_r;
    if (in_acc) begin
      word_cnt_nxt = word_cnt_r + 1'b1;
      unique case (phase_r)
        PH_SEARCH: if (in_word == magic_r) magic_pos_nxt = word_cnt_r;
        PH_COUNT:  pend_count_nxt = hdr_word;
        PH_STEP:   pend_step_nxt  = hdr_word;
        PH_TIME:   push = 1'b1;
        default: ;
      endcase
    end
  end

  assign push_hdr = '{time_bits: hdr_word, step_number: pend_step_r, atom_count: pend_count_r};
  assign push_pos = magic_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      word_cnt_r   <= '0;
      magic_pos_r  <= '0;
      pend_count_r <= '0;
      pend_step_r  <= '0;
    end else begin
      phase_r      <= phase_nxt;
      word_cnt_r   <= word_cnt_nxt;
      magic_pos_r  <= magic_pos_nxt;
      pend_count_r <= pend_count_nxt;
      pend_step_r  <= pend_step_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tfhs_queue.sv =====
// Small FIFO of completed header records between front and back.
`default_nettype none
module tfhs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tfhs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  full,
  output logic                  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tfhs_back.sv =====
// Back end: count lock check, frame numbering, offset delta and output register.
`default_nettype none
module tfhs_back #(
  parameter int OFFSET_BITS = tfhs_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  q_empty,
  input  wire tfhs_pkg::hdr_words_t                  q_hdr,
  input  wire logic [OFFSET_BITS-1:0]                q_pos,
  output logic                                       q_pop,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [tfhs_pkg::OUT_TDATA_W-1:0]           out_tdata
);
  import tfhs_pkg::*;

  logic                   locked_r, locked_nxt;
  logic [WORD_W-1:0]      lock_cnt_r, lock_cnt_nxt;
  logic [OFFSET_BITS-1:0] frames_r, frames_nxt;
  logic [OFFSET_BITS-1:0] prev_ofs_r, prev_ofs_nxt;
  logic                   valid_r, valid_nxt;
  logic [OUT_TDATA_W-1:0] data_r;
  logic                   match, load;
  logic [OFFSET_BITS-1:0] delta;
  // zero-padded copies so any OFFSET_BITS maps onto the 48-bit fields
  logic [OFFSET_BITS+FIELD_OFS_W-1:0] frames_ext, pos_ext, delta_ext;

  assign q_pop = !q_empty && (!valid_r || out_tready);
  assign match = !locked_r || (q_hdr.atom_count == lock_cnt_r);
  assign load  = q_pop && match;
  assign delta = q_pos - prev_ofs_r;

  assign frames_ext = {{FIELD_OFS_W{1'b0}}, frames_r};
  assign pos_ext    = {{FIELD_OFS_W{1'b0}}, q_pos};
  assign delta_ext  = {{FIELD_OFS_W{1'b0}}, delta};

  always_comb begin
    locked_nxt   = locked_r;
    lock_cnt_nxt = lock_cnt_r;
    frames_nxt   = frames_r;
    prev_ofs_nxt = prev_ofs_r;
    valid_nxt    = valid_r;
    if (out_tready) valid_nxt = 1'b0;
    if (q_pop) begin
      valid_nxt = match;
      if (!locked_r) begin
        locked_nxt   = 1'b1;
        lock_cnt_nxt = q_hdr.atom_count;
      end
      if (match) begin
        frames_nxt   = frames_r + 1'b1;
        prev_ofs_nxt = q_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {delta_ext[FIELD_OFS_W-1:0], pos_ext[FIELD_OFS_W-1:0],
                 q_hdr.time_bits, q_hdr.step_number, q_hdr.atom_count,
                 frames_ext[FIELD_OFS_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r   <= 1'b0;
      lock_cnt_r <= '0;
      frames_r   <= '0;
      prev_ofs_r <= '0;
      valid_r    <= 1'b0;
    end else begin
      locked_r   <= locked_nxt;
      lock_cnt_r <= lock_cnt_nxt;
      frames_r   <= frames_nxt;
      prev_ofs_r <= prev_ofs_nxt;
      valid_r    <= valid_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the trajectory frame header scanner: directed and random word streams.
module testbench;
  import tfhs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 38;
  localparam int SETTLE      = 6;

  typedef struct packed {
    logic [FIELD_OFS_W-1:0] offset_delta;
    logic [FIELD_OFS_W-1:0] word_offset;
    logic [WORD_W-1:0]      time_bits;
    logic [WORD_W-1:0]      step_number;
    logic [WORD_W-1:0]      atom_count;
    logic [FIELD_OFS_W-1:0] frame_number;
  } frame_rec_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [WORD_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [WORD_W-1:0]      in_tdata = '0;  // [31:0] word
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [47:0] frame_number, [79:48] atom_count, [111:80] step_number,
  // [143:112] time_bits, [191:144] word_offset, [239:192] offset_delta
  logic [OUT_TDATA_W-1:0] out_tdata;

  trajectory_frame_header_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // scanner shadow state
  logic [WORD_W-1:0]      cur_magic = MAGIC_RESET;
  logic                   cur_swap = 1'b0;
  phase_t                 hdr_phase = PH_SEARCH;
  logic [FIELD_OFS_W-1:0] word_index = '0;
  logic [FIELD_OFS_W-1:0] magic_at = '0;
  logic [FIELD_OFS_W-1:0] last_frame_ofs = '0;
  logic [FIELD_OFS_W-1:0] frames_seen = '0;
  logic [WORD_W-1:0]      lock_count = '0;
  logic                   lock_valid = 1'b0;
  logic [WORD_W-1:0]      hdr_count = '0;
  logic [WORD_W-1:0]      hdr_step = '0;

  frame_rec_t frames_due[$];
  int         mismatch_count = 0;
  int         words_sent = 0;
  int         cycle_count = 0;
  bit         quiet_bus = 1'b0;

  localparam logic [WORD_W-1:0] LOCK_VALUE = 32'hFFFF_FFFF;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 4; i++) r[8*i +: 8] = v[8*(3-i) +: 8];
    return r;
  endfunction

  // advance the shadow scanner by one accepted word
  function automatic void scan_word(input logic [WORD_W-1:0] w);
    frame_rec_t        rec;
    logic [WORD_W-1:0] hw;
    hw = cur_swap ? reverse_bytes(w) : w;
    case (hdr_phase)
      PH_SEARCH: begin
        if (w == cur_magic) begin
          magic_at = word_index;
          hdr_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        hdr_count = hw;
        hdr_phase = PH_STEP;
      end
      PH_STEP: begin
        hdr_step = hw;
        hdr_phase = PH_TIME;
      end
      default: begin
        hdr_phase = PH_SEARCH;
        if (!lock_valid) begin
          lock_count = hdr_count;
          lock_valid = 1'b1;
        end
        if (hdr_count == lock_count) begin
          rec.frame_number = frames_seen;
          rec.atom_count   = hdr_count;
          rec.step_number  = hdr_step;
          rec.time_bits    = hw;
          rec.word_offset  = magic_at;
          rec.offset_delta = magic_at - last_frame_ofs;
          frames_due.push_back(rec);
          frames_seen    = frames_seen + 1'b1;
          last_frame_ofs = magic_at;
        end
      end
    endcase
    word_index = word_index + 1'b1;
  endfunction

  function automatic void report_mismatch(input string what, input logic [47:0] want,
                                          input logic [47:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0h got %0h", what, want, got);
  endfunction

  function automatic void check_field(input string what, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endfunction

  function automatic void check_frame(input frame_rec_t got);
    frame_rec_t want;
    if (frames_due.size() == 0) begin
      report_mismatch("frame with none due, frame_number", '0, got.frame_number);
      return;
    end
    want = frames_due.pop_front();
    check_field("frame_number", want.frame_number, got.frame_number);
    check_field("atom_count", want.atom_count, got.atom_count);
    check_field("step_number", want.step_number, got.step_number);
    check_field("time_bits", want.time_bits, got.time_bits);
    check_field("word_offset", want.word_offset, got.word_offset);
    check_field("offset_delta", want.offset_delta, got.offset_delta);
  endfunction

  // result side: check each accepted request, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_frame(frame_rec_t'(out_tdata));
    out_tready <= quiet_bus || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_word(input logic [WORD_W-1:0] w);
    if (!quiet_bus && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    scan_word(w);
    words_sent++;
  endtask

  task automatic wait_frames_drained();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_MAGIC_WORD) cur_magic = val;
    else cur_swap = val[0];
    @(posedge clk);
  endtask

  task automatic set_scan_config(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] swap);
    wait_frames_drained();
    write_reg(REG_MAGIC_WORD, magic);
    write_reg(REG_SWAP_BYTES, swap);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return cur_magic;
      default: return $urandom;
    endcase
  endfunction

  // one header, mismatched header or stretch of noise
  task automatic send_random_record();
    int          kind;
    logic [31:0] w;
    kind = $urandom_range(99);
    if (kind < 78) begin
      send_word(cur_magic);
      if (kind < 64) send_word(LOCK_VALUE);
      else if (kind < 72) send_word(LOCK_VALUE ^ (32'd1 << $urandom_range(31)));
      else send_word(pick_value());
      send_word(pick_value());
      send_word(pick_value());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        w = $urandom;
        if (kind >= 90) w = cur_magic ^ (32'd1 << $urandom_range(31));
        send_word(w);
      end
    end
  endtask

  task automatic test_random_frames(input int n_words);
    int stop_at;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) send_random_record();
  endtask

  task automatic test_directed_headers();
    send_word('0);
    send_word('1);
    send_word(MAGIC_RESET);     // first header locks the all-ones count
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word('0);
    send_word(MAGIC_RESET);     // back to back with the previous header
    send_word(32'hFFFF_FFFF);
    send_word(32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(MAGIC_RESET);     // magic inside header is plain data
    send_word(32'hFFFF_FFFF);
    send_word(MAGIC_RESET);
    send_word(MAGIC_RESET);
    send_word(MAGIC_RESET);     // count mismatch, no frame
    send_word(32'd5);
    send_word(MAGIC_RESET);
    send_word(32'd2);
    send_word(MAGIC_RESET - 1);
    send_word(MAGIC_RESET);
    send_word(32'hFFFF_FFFF);
    send_word('0);
    send_word(32'd1);
  endtask

  task automatic test_swapped_burst();
    set_scan_config('0, $urandom | 32'd1);
    quiet_bus = 1'b1;
    test_random_frames(300);
    quiet_bus = 1'b0;
  endtask

  task automatic test_drain_pause();
    set_scan_config('1, $urandom & ~32'd1);
    test_random_frames(150);
    wait_frames_drained();
    test_random_frames(150);
  endtask

  task automatic test_random_magic();
    set_scan_config($urandom, 32'd1);
    test_random_frames(280);
  endtask

  // header cut off by the end of the stream
  task automatic test_truncated_header();
    send_word(cur_magic);
    send_word(LOCK_VALUE);
    send_word($urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_headers();
    test_random_frames(300);
    test_swapped_burst();
    test_drain_pause();
    test_random_magic();
    test_truncated_header();
    wait_frames_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tfhs_pkg.sv
design/tfhs_front.sv
design/tfhs_queue.sv
design/tfhs_back.sv
design/trajectory_frame_header_scanner.sv
bench/testbench.sv
